// ===== rtl/exlex_pkg.sv =====
// Shared types, constants and helper functions of the expression lexer.
package exlex_pkg;

  localparam int IDENT_CAPACITY = 64;
  localparam int ID_AW  = $clog2(IDENT_CAPACITY);
  localparam int NUM_W  = 63;
  localparam int LINE_W = 32;
  localparam int COL_W  = 16;
  localparam int KIND_W = 4;
  localparam int ERR_W  = 2;

  localparam logic [NUM_W-1:0]  NUM_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;
  localparam logic [COL_W-1:0]  COL_MAX  = '1;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // Keywords, left justified and padded with zero bytes.
  localparam logic [31:0] KW_IF   = {"if", 16'h0000};
  localparam logic [31:0] KW_THEN = "then";
  localparam logic [31:0] KW_ELSE = "else";

  typedef enum logic [KIND_W-1:0] {
    K_EOF    = 4'd0,
    K_NUMBER = 4'd1,
    K_IDENT  = 4'd2,
    K_IF     = 4'd3,
    K_THEN   = 4'd4,
    K_ELSE   = 4'd5,
    K_PLUS   = 4'd6,
    K_MINUS  = 4'd7,
    K_MUL    = 4'd8,
    K_DIV    = 4'd9,
    K_LPAREN = 4'd10,
    K_RPAREN = 4'd11,
    K_ERROR  = 4'd12
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_TOO_LONG = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_IDENT  = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  halted;
    logic  eoi;
    logic  is_digit;
    logic  is_word;
    logic  is_space;
    logic  is_alpha_us;
    logic  is_op;
    kind_e op_kind;
    logic  ident_full;
    kind_e word_kind;
    logic  rep_last;
    logic  slot_free;
  } dp_status_t;

  typedef struct packed {
    logic  take;
    logic  count;
    logic  acc_ext;
    logic  num_start;
    logic  id_ext;
    logic  id_start;
    logic  id_clear;
    logic  mode_load;
    mode_e mode_val;
    logic  set_halt;
    logic  acc_clear;
    logic  rep_rst;
    logic  rep_inc;
    logic  emit;
    kind_e emit_kind;
    err_e  emit_err;
    logic  emit_num;
    logic  emit_char;
    logic  emit_last;
  } dp_cmd_t;

  // Keyword character at a given position, zero past the fourth.
  function automatic logic [7:0] kw_byte(logic [31:0] word, logic [ID_AW-1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (idx < ID_AW'(4)) begin
      r = word[8*(3-idx[1:0]) +: 8];
    end
    return r;
  endfunction

  function automatic kind_e op_kind(logic [7:0] b);
    kind_e k;
    unique case (b)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_MUL;
      CH_SLASH:  k = K_DIV;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/exlex_ctrl.sv =====
// Controller state machine of the expression lexer: decides and sequences results.
module exlex_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  exlex_pkg::dp_status_t st,
  output exlex_pkg::dp_cmd_t    cmd
);
  import exlex_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_NUM   = 6'b000010,
    S_WORD  = 6'b000100,
    S_FETCH = 6'b001000,
    S_CHAR  = 6'b010000,
    S_TAIL  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   job_num, job_num_next;
  logic   job_id, job_id_next;
  logic   tail_v, tail_v_next;
  kind_e  tail_kind, tail_kind_next;
  err_e   tail_err, tail_err_next;
  state_t after_token;

  assign in_ready    = (state == S_IDLE);
  assign after_token = tail_v ? S_TAIL : S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.mode_val   = MODE_IDLE;
    cmd.emit_kind  = K_EOF;
    cmd.emit_err   = ERR_NONE;
    state_next     = state;
    job_num_next   = job_num;
    job_id_next    = job_id;
    tail_v_next    = tail_v;
    tail_kind_next = tail_kind;
    tail_err_next  = tail_err;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take       = 1'b1;
          job_num_next   = 1'b0;
          job_id_next    = 1'b0;
          tail_v_next    = 1'b0;
          tail_kind_next = K_EOF;
          tail_err_next  = ERR_NONE;
          if (st.halted) begin
            tail_v_next = st.eoi;
          end else if (st.eoi) begin
            job_num_next  = (st.mode == MODE_NUMBER);
            job_id_next   = (st.mode == MODE_IDENT);
            tail_v_next   = 1'b1;
            cmd.mode_load = 1'b1;
          end else begin
            cmd.count = 1'b1;
            if (st.mode == MODE_NUMBER && st.is_digit) begin
              cmd.acc_ext = 1'b1;
            end else if (st.mode == MODE_IDENT && st.is_word) begin
              if (st.ident_full) begin
                // The partial identifier is dropped, not emitted.
                cmd.id_clear   = 1'b1;
                cmd.mode_load  = 1'b1;
                cmd.set_halt   = 1'b1;
                tail_v_next    = 1'b1;
                tail_kind_next = K_ERROR;
                tail_err_next  = ERR_TOO_LONG;
              end else begin
                cmd.id_ext = 1'b1;
              end
            end else begin
              job_num_next  = (st.mode == MODE_NUMBER);
              job_id_next   = (st.mode == MODE_IDENT);
              cmd.mode_load = 1'b1;
              if (st.is_digit) begin
                cmd.mode_val  = MODE_NUMBER;
                cmd.num_start = 1'b1;
              end else if (st.is_alpha_us) begin
                cmd.mode_val = MODE_IDENT;
                cmd.id_start = 1'b1;
              end else if (st.is_space) begin
                tail_v_next = 1'b0;
              end else if (st.is_op) begin
                tail_v_next    = 1'b1;
                tail_kind_next = st.op_kind;
              end else begin
                cmd.set_halt   = 1'b1;
                tail_v_next    = 1'b1;
                tail_kind_next = K_ERROR;
                tail_err_next  = ERR_UNKNOWN;
              end
            end
          end
          if (job_num_next) begin
            state_next = S_NUM;
          end else if (job_id_next) begin
            state_next = S_WORD;
          end else if (tail_v_next) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_NUM: begin
        if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_NUMBER;
          cmd.emit_num  = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.acc_clear = 1'b1;
          state_next    = after_token;
        end
      end
      S_WORD: begin
        if (st.word_kind != K_IDENT) begin
          if (st.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = st.word_kind;
            cmd.emit_last = 1'b1;
            cmd.id_clear  = 1'b1;
            state_next    = after_token;
          end
        end else begin
          cmd.rep_rst = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_FETCH: begin
        // Identifier RAM read data is registered and valid in the cycle after the address.
        state_next = S_CHAR;
      end
      S_CHAR: begin
        if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_IDENT;
          cmd.emit_char = 1'b1;
          cmd.emit_last = st.rep_last;
          if (st.rep_last) begin
            cmd.id_clear = 1'b1;
            state_next   = after_token;
          end else begin
            cmd.rep_inc = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      S_TAIL: begin
        if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = tail_kind;
          cmd.emit_err  = tail_err;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      job_num <= 1'b0;
      job_id  <= 1'b0;
      tail_v  <= 1'b0;
    end else begin
      state   <= state_next;
      job_num <= job_num_next;
      job_id  <= job_id_next;
      tail_v  <= tail_v_next;
    end
  end

  always_ff @(posedge clk) begin
    tail_kind <= tail_kind_next;
    tail_err  <= tail_err_next;
  end

  a_num_job_alone: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !(job_num && job_id))
    else $error("number and identifier flush pending together");

  a_char_follows_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHAR) |-> $past(state) == S_FETCH || $past(state) == S_CHAR)
    else $error("identifier character emitted without a RAM read");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && (state_next != S_IDLE)) |=> !cmd.take)
    else $error("new beat taken while results are still pending");

endmodule

// ===== rtl/exlex_dp.sv =====
// Datapath of the expression lexer: scan state, counters, identifier RAM and result register.
module exlex_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      source_byte,
  input  logic                            end_of_input,
  input  logic                            out_ready,
  input  exlex_pkg::dp_cmd_t              cmd,
  output exlex_pkg::dp_status_t           st,
  output logic                            out_valid,
  output logic [exlex_pkg::KIND_W-1:0]    kind,
  output logic [exlex_pkg::NUM_W-1:0]     number_value,
  output logic [7:0]                      text_char,
  output logic [exlex_pkg::ERR_W-1:0]     error_code,
  output logic [exlex_pkg::LINE_W-1:0]    line_number,
  output logic [exlex_pkg::COL_W-1:0]     column_offset,
  output logic                            last_of_token
);
  import exlex_pkg::*;

  mode_e             mode;
  logic [NUM_W-1:0]  acc;
  logic [ID_AW-1:0]  len;
  logic [ID_AW-1:0]  rep_idx;
  logic [LINE_W-1:0] line;
  logic [COL_W-1:0]  col;
  logic              halted;
  logic              kw_if, kw_then, kw_else;
  logic [7:0]        id_mem [IDENT_CAPACITY];
  logic [7:0]        rd_data;

  logic [3:0]        digit;
  logic              is_digit, is_alpha, is_us, is_space;
  logic [NUM_W+3:0]  acc_prod;
  logic [NUM_W-1:0]  acc_ext_val;
  logic [ID_AW-1:0]  wr_addr;
  logic              id_wr;
  kind_e             word_kind;

  kind_e             kind_q;
  logic [NUM_W-1:0]  num_q;
  logic [7:0]        char_q;
  err_e              err_q;
  logic [LINE_W-1:0] line_q;
  logic [COL_W-1:0]  col_q;
  logic              last_q;

  assign digit    = 4'(source_byte - CH_ZERO);
  assign is_digit = (source_byte >= CH_ZERO) && (source_byte <= CH_NINE);
  assign is_alpha = ((source_byte >= CH_UC_A) && (source_byte <= CH_UC_Z)) ||
                    ((source_byte >= CH_LC_A) && (source_byte <= CH_LC_Z));
  assign is_us    = (source_byte == CH_US);
  assign is_space = (source_byte == CH_SPACE) ||
                    ((source_byte >= CH_TAB) && (source_byte <= CH_CR));

  // acc * 10 + digit; anything above the 63-bit maximum saturates.
  assign acc_prod    = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + (NUM_W+4)'(digit);
  assign acc_ext_val = (acc_prod > {4'b0000, NUM_MAX}) ? NUM_MAX : acc_prod[NUM_W-1:0];

  assign id_wr   = cmd.id_start || cmd.id_ext;
  assign wr_addr = cmd.id_start ? '0 : len;

  always_comb begin
    if (len == ID_AW'(2) && kw_if) begin
      word_kind = K_IF;
    end else if (len == ID_AW'(4) && kw_then) begin
      word_kind = K_THEN;
    end else if (len == ID_AW'(4) && kw_else) begin
      word_kind = K_ELSE;
    end else begin
      word_kind = K_IDENT;
    end
  end

  always_comb begin
    st.mode        = mode;
    st.halted      = halted;
    st.eoi         = end_of_input;
    st.is_digit    = is_digit;
    st.is_word     = is_digit || is_alpha || is_us;
    st.is_space    = is_space;
    st.is_alpha_us = is_alpha || is_us;
    st.op_kind     = op_kind(source_byte);
    st.is_op       = (op_kind(source_byte) != K_ERROR);
    st.ident_full  = (len >= ID_AW'(IDENT_CAPACITY - 1));
    st.word_kind   = word_kind;
    st.rep_last    = (rep_idx == len - ID_AW'(1));
    st.slot_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      acc       <= '0;
      len       <= '0;
      rep_idx   <= '0;
      line      <= LINE_W'(1);
      col       <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.count) begin
        if (source_byte == CH_NL) begin
          if (line != LINE_MAX) begin
            line <= line + LINE_W'(1);
          end
          col <= '0;
        end else if (col != COL_MAX) begin
          col <= col + COL_W'(1);
        end
      end
      if (cmd.mode_load) begin
        mode <= cmd.mode_val;
      end
      if (cmd.acc_ext) begin
        acc <= acc_ext_val;
      end else if (cmd.num_start) begin
        acc <= NUM_W'(digit);
      end else if (cmd.acc_clear) begin
        acc <= '0;
      end
      if (cmd.id_start) begin
        len <= ID_AW'(1);
      end else if (cmd.id_ext) begin
        len <= len + ID_AW'(1);
      end else if (cmd.id_clear) begin
        len <= '0;
      end
      if (cmd.set_halt) begin
        halted <= 1'b1;
      end
      if (cmd.rep_rst) begin
        rep_idx <= '0;
      end else if (cmd.rep_inc) begin
        rep_idx <= rep_idx + ID_AW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Keyword prefix flags follow each character as it is stored.
  always_ff @(posedge clk) begin
    if (cmd.id_start) begin
      kw_if   <= (source_byte == kw_byte(KW_IF, '0));
      kw_then <= (source_byte == kw_byte(KW_THEN, '0));
      kw_else <= (source_byte == kw_byte(KW_ELSE, '0));
    end else if (cmd.id_ext) begin
      kw_if   <= kw_if   && (source_byte == kw_byte(KW_IF, len));
      kw_then <= kw_then && (source_byte == kw_byte(KW_THEN, len));
      kw_else <= kw_else && (source_byte == kw_byte(KW_ELSE, len));
    end
  end

  always_ff @(posedge clk) begin
    if (id_wr) begin
      id_mem[wr_addr] <= source_byte;
    end
    rd_data <= id_mem[rep_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_q <= cmd.emit_kind;
      num_q  <= cmd.emit_num ? acc : '0;
      char_q <= cmd.emit_char ? rd_data : 8'h00;
      err_q  <= cmd.emit_err;
      line_q <= line;
      col_q  <= col;
      last_q <= cmd.emit_last;
    end
  end

  assign kind          = kind_q;
  assign number_value  = num_q;
  assign text_char     = char_q;
  assign error_code    = err_q;
  assign line_number   = line_q;
  assign column_offset = col_q;
  assign last_of_token = last_q;

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  a_replay_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.rep_inc |-> (rep_idx < len - ID_AW'(1)))
    else $error("identifier replay ran past the stored length");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.id_ext |-> (len < ID_AW'(IDENT_CAPACITY - 1)))
    else $error("identifier store written beyond capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

// ===== rtl/expression_lexer_top.sv =====
// Expression lexer top level: joins the controller and the datapath.
// A beat that yields no result leaves the controller idle; the next beat may follow at once.
// A beat that closes a token holds in_ready low until its results are emitted; an
// identifier is first checked against the keywords, then each character is replayed
// through S_FETCH and S_CHAR, set by the registered read of the identifier RAM.
// Synchronous reset returns the scanner to idle, line 1, column 0, halt cleared.
module expression_lexer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   source_byte,
  input  logic                         end_of_input,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [exlex_pkg::KIND_W-1:0] kind,
  output logic [exlex_pkg::NUM_W-1:0]  number_value,
  output logic [7:0]                   text_char,
  output logic [exlex_pkg::ERR_W-1:0]  error_code,
  output logic [exlex_pkg::LINE_W-1:0] line_number,
  output logic [exlex_pkg::COL_W-1:0]  column_offset,
  output logic                         last_of_token
);
  import exlex_pkg::*;

  dp_status_t st;
  dp_cmd_t    cmd;

  exlex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  exlex_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .source_byte   (source_byte),
    .end_of_input  (end_of_input),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .kind          (kind),
    .number_value  (number_value),
    .text_char     (text_char),
    .error_code    (error_code),
    .line_number   (line_number),
    .column_offset (column_offset),
    .last_of_token (last_of_token)
  );

endmodule

// ===== tb/expression_lexer_checker.sv =====
// Checker for the expression lexer: predicts tokens from input beats and compares output beats.
module expression_lexer_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   source_byte,
  input  logic                         end_of_input,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [exlex_pkg::KIND_W-1:0] kind,
  input  logic [exlex_pkg::NUM_W-1:0]  number_value,
  input  logic [7:0]                   text_char,
  input  logic [exlex_pkg::ERR_W-1:0]  error_code,
  input  logic [exlex_pkg::LINE_W-1:0] line_number,
  input  logic [exlex_pkg::COL_W-1:0]  column_offset,
  input  logic                         last_of_token,
  output int                           failures,
  output int                           pending
);
  import exlex_pkg::*;

  localparam logic [63:0] NUM_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    kind_e             kind;
    logic [NUM_W-1:0]  num;
    logic [7:0]        ch;
    err_e              err;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic              last;
  } token_result_t;

  token_result_t     expected_tokens[$];
  mode_e             scan_state;
  logic [NUM_W-1:0]  num_acc;
  logic [7:0]        word_buf[IDENT_CAPACITY];
  int                word_len;
  logic [LINE_W-1:0] cur_line;
  logic [COL_W-1:0]  cur_col;
  logic              stopped;

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit is_alpha(input logic [7:0] b);
    return (b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z);
  endfunction

  function automatic bit word_matches(input string kw);
    if (word_len != kw.len()) return 1'b0;
    for (int i = 0; i < word_len; i++) begin
      if (word_buf[i] != kw[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_token(input kind_e k, input logic [NUM_W-1:0] num,
                             input logic [7:0] ch, input err_e err, input logic last);
    token_result_t t;
    t.kind = k;
    t.num  = num;
    t.ch   = ch;
    t.err  = err;
    t.line = cur_line;
    t.col  = cur_col;
    t.last = last;
    expected_tokens.push_back(t);
  endtask

  // Closes whatever number or identifier is pending.
  task automatic flush_word();
    if (scan_state == MODE_NUMBER) begin
      queue_token(K_NUMBER, num_acc, 8'h00, ERR_NONE, 1'b1);
    end else if (scan_state == MODE_IDENT) begin
      if (word_matches("if")) queue_token(K_IF, '0, 8'h00, ERR_NONE, 1'b1);
      else if (word_matches("then")) queue_token(K_THEN, '0, 8'h00, ERR_NONE, 1'b1);
      else if (word_matches("else")) queue_token(K_ELSE, '0, 8'h00, ERR_NONE, 1'b1);
      else begin
        for (int i = 0; i < word_len; i++) begin
          queue_token(K_IDENT, '0, word_buf[i], ERR_NONE, i == word_len - 1);
        end
      end
    end
    scan_state = MODE_IDLE;
    num_acc    = '0;
    word_len   = 0;
  endtask

  task automatic predict_tokens(input logic [7:0] b, input logic eoi);
    logic [63:0] acc64;
    logic [63:0] digit;
    kind_e       op;
    if (stopped) begin
      if (eoi) queue_token(K_EOF, '0, 8'h00, ERR_NONE, 1'b1);
      return;
    end
    if (eoi) begin
      flush_word();
      queue_token(K_EOF, '0, 8'h00, ERR_NONE, 1'b1);
      return;
    end
    if (b == CH_NL) begin
      if (cur_line != LINE_MAX) cur_line = cur_line + 1'b1;
      cur_col = '0;
    end else if (cur_col != COL_MAX) begin
      cur_col = cur_col + 1'b1;
    end
    if (scan_state == MODE_NUMBER && is_digit(b)) begin
      acc64 = {1'b0, num_acc};
      digit = 64'(b - CH_ZERO);
      if (acc64 > (NUM_LIMIT - digit) / 10) num_acc = NUM_MAX;
      else num_acc = NUM_W'(acc64 * 10 + digit);
      return;
    end
    if (scan_state == MODE_IDENT && (is_alpha(b) || is_digit(b) || b == CH_US)) begin
      if (word_len >= IDENT_CAPACITY - 1) begin
        scan_state = MODE_IDLE;
        word_len   = 0;
        stopped    = 1'b1;
        queue_token(K_ERROR, '0, 8'h00, ERR_TOO_LONG, 1'b1);
        return;
      end
      word_buf[word_len] = b;
      word_len++;
      return;
    end
    flush_word();
    if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return;
    if (is_digit(b)) begin
      scan_state = MODE_NUMBER;
      num_acc    = NUM_W'(b - CH_ZERO);
      return;
    end
    if (is_alpha(b) || b == CH_US) begin
      scan_state  = MODE_IDENT;
      word_buf[0] = b;
      word_len    = 1;
      return;
    end
    case (b)
      CH_PLUS:   op = K_PLUS;
      CH_MINUS:  op = K_MINUS;
      CH_STAR:   op = K_MUL;
      CH_SLASH:  op = K_DIV;
      CH_LPAREN: op = K_LPAREN;
      CH_RPAREN: op = K_RPAREN;
      default: begin
        stopped = 1'b1;
        queue_token(K_ERROR, '0, 8'h00, ERR_UNKNOWN, 1'b1);
        return;
      end
    endcase
    queue_token(op, '0, 8'h00, ERR_NONE, 1'b1);
  endtask

  task automatic report_field(input string name, input logic [63:0] expv,
                              input logic [63:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    token_result_t exp_tok;
    if (rst) begin
      expected_tokens.delete();
      scan_state = MODE_IDLE;
      num_acc    = '0;
      word_len   = 0;
      cur_line   = LINE_W'(1);
      cur_col    = '0;
      stopped    = 1'b0;
      failures   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got kind %0d", $time, kind);
          failures++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          report_field("kind", exp_tok.kind, kind);
          report_field("number_value", exp_tok.num, number_value);
          report_field("text_char", exp_tok.ch, text_char);
          report_field("error_code", exp_tok.err, error_code);
          report_field("line_number", exp_tok.line, line_number);
          report_field("column_offset", exp_tok.col, column_offset);
          report_field("last_of_token", exp_tok.last, last_of_token);
        end
      end
      if (in_valid && in_ready) predict_tokens(source_byte, end_of_input);
    end
    pending = expected_tokens.size();
  end

endmodule

// ===== tb/tb_expression_lexer_top.sv =====
// Testbench top for the expression lexer: clock, reset, stimulus, watchdog and verdict.
module tb_expression_lexer_top;
  import exlex_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        source_byte;
  logic              end_of_input;
  logic              out_valid;
  logic              out_ready;
  logic [KIND_W-1:0] kind;
  logic [NUM_W-1:0]  number_value;
  logic [7:0]        text_char;
  logic [ERR_W-1:0]  error_code;
  logic [LINE_W-1:0] line_number;
  logic [COL_W-1:0]  column_offset;
  logic              last_of_token;
  int                failures;
  int                pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent = 0;
  int quiet_cycles = 0;

  expression_lexer_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .source_byte(source_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .number_value(number_value), .text_char(text_char),
    .error_code(error_code), .line_number(line_number),
    .column_offset(column_offset), .last_of_token(last_of_token)
  );

  expression_lexer_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .source_byte(source_byte), .end_of_input(end_of_input),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .number_value(number_value), .text_char(text_char),
    .error_code(error_code), .line_number(line_number),
    .column_offset(column_offset), .last_of_token(last_of_token),
    .failures(failures), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // The run is stopped when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit is_known(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_UC_A && b <= CH_UC_Z) ||
           (b >= CH_LC_A && b <= CH_LC_Z) || b == CH_US || b == CH_SPACE ||
           (b >= CH_TAB && b <= CH_CR) || b == CH_PLUS || b == CH_MINUS ||
           b == CH_STAR || b == CH_SLASH || b == CH_LPAREN || b == CH_RPAREN;
  endfunction

  function automatic logic [7:0] random_word_char(input bit first);
    int sel;
    sel = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (sel < 26) return 8'(CH_UC_A + sel);
    if (sel < 52) return 8'(CH_LC_A + sel - 26);
    if (sel == 52) return CH_US;
    return 8'(CH_ZERO + sel - 53);
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eoi);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    source_byte  <= b;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // The byte beside an end mark is ignored, so it carries a random value.
  task automatic send_end();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_ident(input int len);
    send_beat(random_word_char(1'b1), 1'b0);
    for (int i = 1; i < len; i++) send_beat(random_word_char(1'b0), 1'b0);
  endtask

  task automatic send_random_token();
    int sel;
    int len;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 5);
      repeat (len) send_beat(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    end else if (sel < 50) begin
      case ($urandom_range(0, 19))
        0: begin
          // A space keeps the next token from growing this one past capacity.
          send_ident($urandom_range(62, 63));
          send_beat(CH_SPACE, 1'b0);
        end
        1:       send_text("if");
        2:       send_text("then");
        3:       send_text("else");
        4:       send_text("iff");
        5:       send_text("the");
        6:       send_text("elsewhere");
        default: send_ident($urandom_range(1, 8));
      endcase
    end else if (sel < 70) begin
      case ($urandom_range(0, 5))
        0:       send_beat(CH_PLUS, 1'b0);
        1:       send_beat(CH_MINUS, 1'b0);
        2:       send_beat(CH_STAR, 1'b0);
        3:       send_beat(CH_SLASH, 1'b0);
        4:       send_beat(CH_LPAREN, 1'b0);
        default: send_beat(CH_RPAREN, 1'b0);
      endcase
    end else if (sel < 85) begin
      b = 8'($urandom_range(9, 14));
      send_beat((b == 8'd14) ? CH_SPACE : b, 1'b0);
    end else if (sel < 91) begin
      send_end();
    end else begin
      do b = 8'($urandom_range(0, 127)); while (!is_known(b));
      send_beat(b, 1'b0);
    end
  endtask

  initial begin
    logic [7:0] bad;
    rst          = 1'b1;
    in_valid     = 1'b0;
    source_byte  = 8'h00;
    end_of_input = 1'b0;
    out_ready    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 38;
    recv_idle_pct = 73;
    // Keywords, every operator, identifier and number closing on each other,
    // a pending number at the end mark, and repeated end marks.
    send_text("if then");
    send_beat(CH_TAB, 1'b0);
    send_text("else(_9+1x)*/-");
    send_beat(CH_NL, 1'b0);
    send_beat(CH_CR, 1'b0);
    send_text("7");
    send_end();
    send_end();
    send_text("abc");
    send_end();
    while (beats_sent < 115) send_random_token();

    send_idle_pct = 73;
    recv_idle_pct = 38;
    while (beats_sent < 230) send_random_token();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (beats_sent < 345) send_random_token();

    // Only one error can be seen per run, since only a reset clears the halt.
    if ($urandom_range(0, 1) == 1) begin
      send_text("ab");
      do bad = 8'($urandom_range(0, 255)); while (is_known(bad));
      send_beat(bad, 1'b0);
    end else begin
      send_beat(CH_SPACE, 1'b0);
      send_ident(IDENT_CAPACITY);
    end
    repeat (8) send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
    send_end();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
